// ===== src/pnguf_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none

package pnguf_pkg;

	// Default sizes of the line buffer and of the left-neighbor history
	localparam int unsigned MAX_ROW_BYTES_DEF = 8192;
	localparam int unsigned MAX_BPP_DEF       = 8;

	// Configuration register widths
	localparam int unsigned BPP_W        = 4;
	localparam int unsigned ROW_BYTES_W  = 14;
	localparam int unsigned IMAGE_ROWS_W = 16;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	// Entries in the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BPP        = 2'd0,
		CFG_ROW_BYTES  = 2'd1,
		CFG_IMAGE_ROWS = 2'd2
	} cfg_reg_t;

	// Predictor chosen for a row; unknown filter codes map to none
	typedef enum logic [2:0] {
		FILT_NONE,
		FILT_SUB,
		FILT_UP,
		FILT_AVG,
		FILT_PAETH
	} filt_t;

	// Classified data byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		filt_t      filt;
		logic       has_left;
		logic       first_row;
		logic       row_end;
		logic       image_end;
	} item_ctrl_t;

endpackage

`default_nettype wire

// ===== src/pnguf_front.sv =====
// Front end: takes stream bytes, tracks row position and classifies data bytes.
`default_nettype none

module pnguf_front #(
	parameter int unsigned MAX_ROW_BYTES = pnguf_pkg::MAX_ROW_BYTES_DEF,
	parameter int unsigned MAX_BPP       = pnguf_pkg::MAX_BPP_DEF,
	localparam int unsigned IDX_W  = $clog2(MAX_ROW_BYTES),
	localparam int unsigned SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [7:0]                           filtered_byte,
	input  wire logic [pnguf_pkg::BPP_W-1:0]          bytes_per_pixel,
	input  wire logic [pnguf_pkg::ROW_BYTES_W-1:0]    row_bytes,
	input  wire logic [pnguf_pkg::IMAGE_ROWS_W-1:0]   image_rows,
	input  wire logic                                 q_full,
	output logic                                      push,
	output pnguf_pkg::item_ctrl_t                     ctrl,
	output logic [IDX_W-1:0]                          idx,
	output logic [SLOT_W-1:0]                         slot
);
	import pnguf_pkg::*;

	localparam int unsigned CMP_W = (IDX_W + 1 > ROW_BYTES_W) ? IDX_W + 1 : ROW_BYTES_W;
	localparam int unsigned HL_W  = (IDX_W > BPP_W) ? IDX_W : BPP_W;

	// PNG filter type codes
	localparam logic [7:0] PNG_SUB   = 8'd1;
	localparam logic [7:0] PNG_UP    = 8'd2;
	localparam logic [7:0] PNG_AVG   = 8'd3;
	localparam logic [7:0] PNG_PAETH = 8'd4;

	logic                    expect_filter_q;
	logic [IDX_W-1:0]        col_q;
	logic [IMAGE_ROWS_W-1:0] row_q;
	filt_t                   filt_q;
	logic [SLOT_W-1:0]       mod_q [MAX_BPP];

	logic                    accept;
	filt_t                   filt_in;
	logic [BPP_W-1:0]        bpp_eff;
	logic [SLOT_W-1:0]       bpp_sel;
	logic [ROW_BYTES_W-1:0]  rb_nz;
	logic [IDX_W:0]          idx_inc;
	logic                    rend;
	logic [IMAGE_ROWS_W:0]   row_inc;
	logic [IMAGE_ROWS_W-1:0] rows_nz;
	logic                    img_done;

	// Handshake: filter bytes need no queue space
	assign in_ready = expect_filter_q || !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && !expect_filter_q;

	// Filter code classification
	always_comb begin
		case (filtered_byte)
			PNG_SUB:   filt_in = FILT_SUB;
			PNG_UP:    filt_in = FILT_UP;
			PNG_AVG:   filt_in = FILT_AVG;
			PNG_PAETH: filt_in = FILT_PAETH;
			default:   filt_in = FILT_NONE;
		endcase
	end

	// Effective pixel stride, clamped to 1..MAX_BPP
	always_comb begin
		if (bytes_per_pixel == '0)
			bpp_eff = BPP_W'(1);
		else if (bytes_per_pixel > BPP_W'(MAX_BPP))
			bpp_eff = BPP_W'(MAX_BPP);
		else
			bpp_eff = bytes_per_pixel;
	end
	assign bpp_sel = SLOT_W'(bpp_eff - BPP_W'(1));

	// Position in the pixel: one column counter per possible stride
	assign slot = mod_q[bpp_sel];

	// Row end: position reaches row length (zero counts as one) or the buffer size
	assign rb_nz   = (row_bytes == '0) ? ROW_BYTES_W'(1) : row_bytes;
	assign idx_inc = {1'b0, col_q} + 1'b1;
	assign rend    = (CMP_W'(idx_inc) >= CMP_W'(rb_nz)) || (col_q == IDX_W'(MAX_ROW_BYTES - 1));

	// Image end on the last row
	assign rows_nz  = (image_rows == '0) ? IMAGE_ROWS_W'(1) : image_rows;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign img_done = row_inc >= {1'b0, rows_nz};

	// Classified item
	assign idx            = col_q;
	assign ctrl.data      = filtered_byte;
	assign ctrl.filt      = filt_q;
	assign ctrl.has_left  = HL_W'(col_q) >= HL_W'(bpp_eff);
	assign ctrl.first_row = (row_q == '0);
	assign ctrl.row_end   = rend;
	assign ctrl.image_end = rend && img_done;

	// Row and column tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_filter_q <= 1'b1;
			col_q           <= '0;
			row_q           <= '0;
			filt_q          <= FILT_NONE;
			for (int k = 0; k < MAX_BPP; k++)
				mod_q[k] <= '0;
		end else if (accept) begin
			if (expect_filter_q) begin
				filt_q          <= filt_in;
				expect_filter_q <= 1'b0;
			end else if (rend) begin
				expect_filter_q <= 1'b1;
				col_q           <= '0;
				row_q           <= img_done ? '0 : row_inc[IMAGE_ROWS_W-1:0];
				for (int k = 0; k < MAX_BPP; k++)
					mod_q[k] <= '0;
			end else begin
				col_q <= idx_inc[IDX_W-1:0];
				for (int k = 0; k < MAX_BPP; k++)
					mod_q[k] <= (mod_q[k] == SLOT_W'(k)) ? '0 : mod_q[k] + 1'b1;
			end
		end
	end

	// A row end sends the next byte to the filter slot
	a_rend_filter: assert property (@(posedge clk) disable iff (!arst_n)
		push && ctrl.row_end |=> expect_filter_q)
		else $error("front: row end did not arm filter byte");

	// An image end restarts the row count
	a_iend_rows: assert property (@(posedge clk) disable iff (!arst_n)
		push && ctrl.image_end |=> row_q == '0)
		else $error("front: image end did not restart rows");

endmodule

`default_nettype wire

// ===== src/pnguf_fifo.sv =====
// Short request queue between the front end and the reconstruction back end.
`default_nettype none

module pnguf_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = pnguf_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  rvalid,
	output logic [WIDTH-1:0]      rdata
);
	import pnguf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Never written while full, never read while empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !rvalid))
		else $error("fifo: overflow or underflow");

endmodule

`default_nettype wire

// ===== src/pnguf_back.sv =====
// Back end: line buffer, neighbor history and predictor arithmetic.
`default_nettype none

module pnguf_back #(
	parameter int unsigned MAX_ROW_BYTES = pnguf_pkg::MAX_ROW_BYTES_DEF,
	parameter int unsigned MAX_BPP       = pnguf_pkg::MAX_BPP_DEF,
	localparam int unsigned IDX_W  = $clog2(MAX_ROW_BYTES),
	localparam int unsigned SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   head_valid,
	input  wire pnguf_pkg::item_ctrl_t  head_ctrl,
	input  wire logic [IDX_W-1:0]       head_idx,
	input  wire logic [SLOT_W-1:0]      head_slot,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  pixel_byte,
	output logic                        row_end,
	output logic                        image_end
);
	import pnguf_pkg::*;

	// Paeth predictor: nearest of a, b, c to a + b - c, ties to a then b
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] pa;
		logic signed [9:0] pb;
		logic signed [9:0] pc;
		logic [9:0]        da;
		logic [9:0]        db;
		logic [9:0]        dc;
		pa = $signed({2'b00, b}) - $signed({2'b00, c});
		pb = $signed({2'b00, a}) - $signed({2'b00, c});
		pc = pa + pb;
		da = pa[9] ? 10'(-pa) : 10'(pa);
		db = pb[9] ? 10'(-pb) : 10'(pb);
		dc = pc[9] ? 10'(-pc) : 10'(pc);
		if (da <= db && da <= dc)
			return a;
		else if (db <= dc)
			return b;
		else
			return c;
	endfunction

	// Previous row
	logic [7:0]        line_mem [MAX_ROW_BYTES];

	// Last stride of bytes of this row and the ones above them
	logic [7:0]        recent_cur_q [MAX_BPP];
	logic [7:0]        recent_up_q  [MAX_BPP];

	// Stage 1: item plus line buffer read
	logic              valid_s1;
	item_ctrl_t        ctrl_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [7:0]        up_rd_s1;
	logic              byp_s1;
	logic [7:0]        byp_data_s1;

	// Stage 2: result register
	logic              valid_s2;
	logic [7:0]        pixel_s2;
	logic              row_end_s2;
	logic              image_end_s2;

	logic              adv;
	logic [7:0]        nb_a;
	logic [7:0]        nb_b;
	logic [7:0]        nb_c;
	logic [8:0]        avg_sum;
	logic [7:0]        pred;
	logic [7:0]        res;

	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign pop = head_valid && (!valid_s1 || adv);

	// Neighbors; a byte written in the previous cycle is taken from the bypass
	assign nb_a = ctrl_s1.has_left ? recent_cur_q[slot_s1] : 8'd0;
	assign nb_b = ctrl_s1.first_row ? 8'd0 : (byp_s1 ? byp_data_s1 : up_rd_s1);
	assign nb_c = (ctrl_s1.has_left && !ctrl_s1.first_row) ? recent_up_q[slot_s1] : 8'd0;
	assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

	// Predictor select and reconstruction
	always_comb begin
		case (ctrl_s1.filt)
			FILT_SUB:   pred = nb_a;
			FILT_UP:    pred = nb_b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
			default:    pred = 8'd0;
		endcase
	end
	assign res = ctrl_s1.data + pred;

	// Line buffer: read on dequeue, write on completion
	always_ff @(posedge clk) begin
		if (adv)
			line_mem[idx_s1] <= res;
		if (pop)
			up_rd_s1 <= line_mem[head_idx];
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_s1     <= head_ctrl;
			idx_s1      <= head_idx;
			slot_s1     <= head_slot;
			byp_s1      <= adv && (idx_s1 == head_idx);
			byp_data_s1 <= res;
		end
		if (adv) begin
			pixel_s2     <= res;
			row_end_s2   <= ctrl_s1.row_end;
			image_end_s2 <= ctrl_s1.image_end;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// Neighbor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BPP; k++) begin
				recent_cur_q[k] <= 8'd0;
				recent_up_q[k]  <= 8'd0;
			end
		end else if (adv) begin
			recent_cur_q[slot_s1] <= res;
			recent_up_q[slot_s1]  <= nb_b;
		end
	end

	assign out_valid  = valid_s2;
	assign pixel_byte = pixel_s2;
	assign row_end    = row_end_s2;
	assign image_end  = image_end_s2;

	// A completed item always lands in the result register
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("back: completed item lost");

	// Same-address write and read in one cycle must take the bypass
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		pop && adv && (idx_s1 == head_idx) |=> byp_s1 && (byp_data_s1 == pixel_s2))
		else $error("back: line buffer bypass missed");

endmodule

`default_nettype wire

// ===== src/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: configuration registers and block wiring.
`default_nettype none

// PNG scanline unfilter. Takes an inflated PNG image stream one byte per request;
// the first byte of each row selects the filter (None, Sub, Up, Average, Paeth;
// other codes pass data unchanged) and gives no result, every data byte gives one
// reconstructed byte with row_end and image_end flags. Sustained rate is one byte
// per clock while out_ready is high. The rate is set by the loop from a finished
// byte back to the left neighbor of the next byte (stride 1) and by the line
// buffer, which has one read and one write port: it is read when a byte leaves
// the queue and written when a byte completes, often in the same clock, with a
// bypass between the two. The line buffer holds
// MAX_ROW_BYTES bytes and is not cleared: on the first row of an image the value
// read from it is ignored, so no clearing pass is needed; growing row_bytes inside
// an image reads bytes never written and gives undefined data there.
// Configuration writes take effect at once and are meant for idle periods only.
module png_scanline_unfilter #(
	parameter int unsigned MAX_ROW_BYTES = pnguf_pkg::MAX_ROW_BYTES_DEF,
	parameter int unsigned MAX_BPP       = pnguf_pkg::MAX_BPP_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pnguf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pnguf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         filtered_byte,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              pixel_byte,
	output logic                                    row_end,
	output logic                                    image_end
);
	import pnguf_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_ROW_BYTES);
	localparam int unsigned SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	localparam int unsigned Q_W    = $bits(item_ctrl_t) + IDX_W + SLOT_W;

	logic [BPP_W-1:0]        bpp_q;
	logic [ROW_BYTES_W-1:0]  row_bytes_q;
	logic [IMAGE_ROWS_W-1:0] image_rows_q;

	logic              q_full;
	logic              push;
	item_ctrl_t        f_ctrl;
	logic [IDX_W-1:0]  f_idx;
	logic [SLOT_W-1:0] f_slot;
	logic              pop;
	logic              head_valid;
	logic [Q_W-1:0]    head_word;
	item_ctrl_t        head_ctrl;
	logic [IDX_W-1:0]  head_idx;
	logic [SLOT_W-1:0] head_slot;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= BPP_W'(1);
			row_bytes_q  <= ROW_BYTES_W'(1);
			image_rows_q <= IMAGE_ROWS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BPP:        bpp_q        <= cfg_data[BPP_W-1:0];
				CFG_ROW_BYTES:  row_bytes_q  <= cfg_data[ROW_BYTES_W-1:0];
				CFG_IMAGE_ROWS: image_rows_q <= cfg_data[IMAGE_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end
	pnguf_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_BPP      (MAX_BPP)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.filtered_byte  (filtered_byte),
		.bytes_per_pixel(bpp_q),
		.row_bytes      (row_bytes_q),
		.image_rows     (image_rows_q),
		.q_full         (q_full),
		.push           (push),
		.ctrl           (f_ctrl),
		.idx            (f_idx),
		.slot           (f_slot)
	);

	// Request queue
	pnguf_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({f_ctrl, f_idx, f_slot}),
		.full  (q_full),
		.pop   (pop),
		.rvalid(head_valid),
		.rdata (head_word)
	);

	assign {head_ctrl, head_idx, head_slot} = head_word;

	// Back end
	pnguf_back #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_BPP      (MAX_BPP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_ctrl (head_ctrl),
		.head_idx  (head_idx),
		.head_slot (head_slot),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_byte(pixel_byte),
		.row_end   (row_end),
		.image_end (image_end)
	);

endmodule

`default_nettype wire
